### sv/utf8_to_utf16_decoder_assert.svh
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define U2U_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u check failed");

// next-cycle implication, sampled on clk, off during reset
`define U2U_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2u check failed");

`endif

### sv/u2u_pkg.sv
package u2u_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] SUPP_BASE      = 21'h10000;
    localparam logic [15:0]     HI_SURR_BIAS   = 16'hD7C0;
    localparam logic [5:0]      LO_SURR_PREFIX = 6'b110111;
    localparam logic [1:0]      CONT_TAG       = 2'b10;

    typedef struct packed {
        logic            push;
        logic [CP_W-1:0] code_point;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### sv/u2u_front.sv
module u2u_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         in_byte,
    input  u2u_pkg::q_status_t q_status,
    output u2u_pkg::job_t      job
);

    logic [1:0]                 pending_count_reg;
    logic [1:0]                 pending_count_next;
    logic [u2u_pkg::CP_W-1:0]   code_accumulator_reg;
    logic [u2u_pkg::CP_W-1:0]   code_accumulator_next;
    logic                       accept;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !q_status.full;

    always_comb
    begin
        pending_count_next    = pending_count_reg;
        code_accumulator_next = code_accumulator_reg;
        job.push              = 1'b0;
        job.code_point        = {code_accumulator_reg[u2u_pkg::CP_W-7:0], in_byte[5:0]};
        if (accept)
        begin
            if ((pending_count_reg != 2'd0) && (in_byte[7:6] == u2u_pkg::CONT_TAG))
            begin
                code_accumulator_next = {code_accumulator_reg[u2u_pkg::CP_W-7:0],
                                         in_byte[5:0]};
                pending_count_next    = pending_count_reg - 2'd1;
                job.push              = (pending_count_reg == 2'd1);
            end
            else
            begin
                // drop any partial sequence, decode this byte afresh
                pending_count_next = 2'd0;
                case (in_byte) inside
                    [8'h00:8'h7F]:
                    begin
                        job.push       = 1'b1;
                        job.code_point = {{(u2u_pkg::CP_W-8){1'b0}}, in_byte};
                    end
                    [8'hC0:8'hDF]:
                    begin
                        pending_count_next    = 2'd1;
                        code_accumulator_next = {{(u2u_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
                    end
                    [8'hE0:8'hEF]:
                    begin
                        pending_count_next    = 2'd2;
                        code_accumulator_next = {{(u2u_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
                    end
                    [8'hF0:8'hF7]:
                    begin
                        pending_count_next    = 2'd3;
                        code_accumulator_next = {{(u2u_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
                    end
                    default:
                    begin
                        pending_count_next = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg    <= 2'd0;
            code_accumulator_reg <= '0;
        end
        else
        begin
            pending_count_reg    <= pending_count_next;
            code_accumulator_reg <= code_accumulator_next;
        end
    end

endmodule

### sv/u2u_queue.sv
module u2u_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  u2u_pkg::job_t            job,
    input  logic                     pop,
    output u2u_pkg::q_status_t       q_status,
    output logic [u2u_pkg::CP_W-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [u2u_pkg::CP_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     do_push;
    logic                     do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = job.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign rd_data        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job.code_point;
        end
    end

endmodule

### sv/u2u_back.sv
module u2u_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  u2u_pkg::q_status_t       q_status,
    input  logic [u2u_pkg::CP_W-1:0] rd_data,
    output logic                     pop,
    output logic                     unit_valid,
    input  logic                     unit_stall,
    output logic [15:0]              code_unit,
    output logic                     last_unit
);

    logic        unit_valid_reg;
    logic        unit_valid_next;
    logic [15:0] code_unit_reg;
    logic [15:0] code_unit_next;
    logic        last_unit_reg;
    logic        last_unit_next;
    logic        low_pending_reg;
    logic        low_pending_next;
    logic [15:0] low_unit_reg;
    logic [15:0] low_unit_next;
    logic        load_ok;
    logic        is_supp;

    assign load_ok    = !unit_valid_reg || !unit_stall;
    assign is_supp    = (rd_data >= u2u_pkg::SUPP_BASE);
    assign pop        = load_ok && !low_pending_reg && !q_status.empty;
    assign unit_valid = unit_valid_reg;
    assign code_unit  = code_unit_reg;
    assign last_unit  = last_unit_reg;

    always_comb
    begin
        unit_valid_next  = unit_valid_reg;
        code_unit_next   = code_unit_reg;
        last_unit_next   = last_unit_reg;
        low_pending_next = low_pending_reg;
        low_unit_next    = low_unit_reg;
        if (load_ok)
        begin
            if (low_pending_reg)
            begin
                unit_valid_next  = 1'b1;
                code_unit_next   = low_unit_reg;
                last_unit_next   = 1'b1;
                low_pending_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                unit_valid_next = 1'b1;
                if (is_supp)
                begin
                    // high half now, hold low half for the next transaction
                    code_unit_next   = u2u_pkg::HI_SURR_BIAS
                                       + {5'd0, rd_data[u2u_pkg::CP_W-1:10]};
                    last_unit_next   = 1'b0;
                    low_pending_next = 1'b1;
                    low_unit_next    = {u2u_pkg::LO_SURR_PREFIX, rd_data[9:0]};
                end
                else
                begin
                    code_unit_next = rd_data[15:0];
                    last_unit_next = 1'b1;
                end
            end
            else
            begin
                unit_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_valid_reg  <= 1'b0;
            low_pending_reg <= 1'b0;
        end
        else
        begin
            unit_valid_reg  <= unit_valid_next;
            low_pending_reg <= low_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_unit_reg <= code_unit_next;
        last_unit_reg <= last_unit_next;
        low_unit_reg  <= low_unit_next;
    end

endmodule

### sv/utf8_to_utf16_decoder.sv
// Path: a byte that completes a character is written into the queue, then popped into the output
//   register once that register is free, to present its first code unit. Throughput: one byte per cycle
//   while byte_stall is low; a supplementary character occupies the output for both of its code units,
//   the queue between decoder and emitter absorbs it and byte_stall rises only when it is full.
// Reset (rst_n low, asynchronous): clears pending count, accumulator, queue and output valid.
module utf8_to_utf16_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic        last_unit
);

    u2u_pkg::job_t            job;
    u2u_pkg::q_status_t       q_status;
    logic                     pop;
    logic [u2u_pkg::CP_W-1:0] rd_data;

    u2u_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .q_status   (q_status),
        .job        (job)
    );

    u2u_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .pop      (pop),
        .q_status (q_status),
        .rd_data  (rd_data)
    );

    u2u_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .rd_data    (rd_data),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit)
    );

endmodule

### sv/u2u_checker.sv
`include "utf8_to_utf16_decoder_assert.svh"

module u2u_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  in_byte,
    input logic        unit_valid,
    input logic        unit_stall,
    input logic [15:0] code_unit,
    input logic        last_unit
);

    logic in_hold;
    logic out_hold;
    logic hi_taken;
    logic lo_unit;

    assign in_hold  = byte_valid && byte_stall;
    assign out_hold = unit_valid && unit_stall;
    assign hi_taken = unit_valid && !last_unit && !unit_stall;
    assign lo_unit  = unit_valid && last_unit && (code_unit[15:10] == 6'b110111);

    `U2U_ASSERT_NEXT(a_in_hold, in_hold, byte_valid && $stable(in_byte))
    `U2U_ASSERT_NEXT(a_out_hold_valid, out_hold, unit_valid)
    `U2U_ASSERT_NEXT(a_out_hold_data, out_hold, $stable(code_unit) && $stable(last_unit))
    `U2U_ASSERT_NOW(a_first_is_high, unit_valid && !last_unit, code_unit[15:11] == 5'b11011)
    `U2U_ASSERT_NEXT(a_low_follows, hi_taken, lo_unit)

endmodule

bind utf8_to_utf16_decoder u2u_checker u_u2u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .in_byte    (in_byte),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .last_unit  (last_unit)
);
